@@ hw/rtl/ils_pkg.sv @@
// Shared types, codes and default sizes for the indexed list store.
package ils_pkg;

   // Default sizes handed to the top level's parameters.
   localparam int DEF_STORE_DEPTH = 256;
   localparam int DEF_HANDLE_BITS = 32;

   // Widest handle the store may be built for; handles are widened through this.
   localparam int HANDLE_MAX_W = 64;

   // Fixed field widths of the request and response beats.
   localparam int CMD_W      = 3;
   localparam int POS_W      = 8;
   localparam int HANDLE_W   = 32;
   localparam int STATUS_W   = 2;
   localparam int LEN_W      = 9;
   localparam int CFG_W      = 9;
   localparam int CSR_INDEX_W = 1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_START_CAP  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GROW_BLOCK = 1'd1;

   // Configuration reset values.
   localparam logic [CFG_W-1:0] START_CAP_RESET  = 9'd0;
   localparam logic [CFG_W-1:0] GROW_BLOCK_RESET = 9'd8;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TRIM   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd5;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOROOM = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [POS_W-1:0]    position;
      logic [HANDLE_W-1:0] handle_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle_out;
      logic [LEN_W-1:0]    length;
      logic [LEN_W-1:0]    room;
   } rsp_type;

   // Completion report of the growth unit.
   typedef struct packed {
      logic done;
      logic no_room;
   } grow_status_type;

endpackage

@@ hw/rtl/ils_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module ils_ram #(
   parameter int WIDTH = ils_pkg::DEF_HANDLE_BITS,
   parameter int DEPTH = ils_pkg::DEF_STORE_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; contents are undefined until written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/ils_grow.sv @@
// Growth unit: works out the new capacity in whole blocks with a bit-serial remainder.
module ils_grow #(
   parameter int ARITH_W     = 11,
   parameter int STORE_DEPTH = ils_pkg::DEF_STORE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ARITH_W-1:0]             need,
   input  logic [ARITH_W-1:0]             cap,
   input  logic [ils_pkg::CFG_W-1:0]      block,
   output ils_pkg::grow_status_type       status,
   output logic [ARITH_W-1:0]             grown
);

   localparam int STEP_W = $clog2(ARITH_W + 1);
   localparam logic [ARITH_W-1:0] DEPTH_LIMIT = ARITH_W'(STORE_DEPTH);

   typedef enum logic [1:0] {G_IDLE, G_DIVIDE, G_SUM} grow_state_type;

   grow_state_type              state_ff, state_in;
   logic [ARITH_W-1:0]          dividend_ff, dividend_in;
   logic [ils_pkg::CFG_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [ARITH_W-1:0]          need_ff, need_in;
   logic [ils_pkg::CFG_W-1:0]   block_ff, block_in;
   logic                        done_ff, done_in;
   logic                        no_room_ff, no_room_in;
   logic [ARITH_W-1:0]          grown_ff, grown_in;

   logic [ils_pkg::CFG_W:0]     rem_shift;
   logic [ils_pkg::CFG_W:0]     block_x;
   logic [ils_pkg::CFG_W-1:0]   rem_next;
   logic [ARITH_W-1:0]          sum_w;

   // One restoring step: bring in the next dividend bit and subtract the block if it fits.
   assign rem_shift = {rem_ff, dividend_ff[ARITH_W-1]};
   assign block_x   = {1'b0, block_ff};
   assign rem_next  = (rem_shift >= block_x) ? ils_pkg::CFG_W'(rem_shift - block_x)
                                             : rem_shift[ils_pkg::CFG_W-1:0];

   // The smallest multiple of the block above the shortfall is shortfall - rem + block,
   // so the new capacity is need + block - rem.
   assign sum_w = need_ff + ARITH_W'(block_ff) - ARITH_W'(rem_ff);

   // Next-state logic.
   always_comb begin
      state_in    = state_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      need_in     = need_ff;
      block_in    = block_ff;
      done_in     = 1'b0;
      no_room_in  = no_room_ff;
      grown_in    = grown_ff;
      unique case (state_ff)
         G_IDLE: begin
            if (start) begin
               dividend_in = need - cap;
               rem_in      = '0;
               step_in     = STEP_W'(ARITH_W);
               need_in     = need;
               block_in    = block;
               state_in    = G_DIVIDE;
            end
         end
         G_DIVIDE: begin
            dividend_in = dividend_ff << 1;
            rem_in      = rem_next;
            step_in     = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = G_SUM;
            end
         end
         G_SUM: begin
            grown_in   = sum_w;
            no_room_in = sum_w > DEPTH_LIMIT;
            done_in    = 1'b1;
            state_in   = G_IDLE;
         end
         default: begin
            state_in = G_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      need_ff     <= need_in;
      block_ff    <= block_in;
      no_room_ff  <= no_room_in;
      grown_ff    <= grown_in;
   end

   assign status.done    = done_ff;
   assign status.no_room = no_room_ff;
   assign grown          = grown_ff;

endmodule

@@ hw/rtl/indexed_list_store.sv @@
// Top level of the indexed list store: command sequencer around the slot memory.
//
// An ordered list of element handles held in one slot memory of STORE_DEPTH entries.
// Each request beat carries get, set, insert, remove, trim or append and yields exactly
// one response beat with status, the handle read by get, the length and the capacity.
// One request is worked on at a time. Insert and remove move one entry per cycle through
// the memory's single write port, and set or insert beyond the end writes the zero gap
// one slot per cycle. Growth adds a bit-serial block-count unit. Slots at or beyond the
// length are never read, and any gap is zero-written as the list extends, so reset and
// a write of the start capacity take effect at once with no clearing pass. A response
// waiting in the output register does not stop the next request beat from being taken.
module indexed_list_store #(
   parameter int STORE_DEPTH = ils_pkg::DEF_STORE_DEPTH,
   parameter int HANDLE_BITS = ils_pkg::DEF_HANDLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ils_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ils_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write,
   input  logic [ils_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ils_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int ADDR_W  = $clog2(STORE_DEPTH);
   localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
   localparam int ARITH_W = ((CNT_W > ils_pkg::CFG_W) ? CNT_W : ils_pkg::CFG_W) + 2;
   localparam int WIDE_W  = ils_pkg::HANDLE_MAX_W;
   localparam logic [ARITH_W-1:0] DEPTH_W = ARITH_W'(STORE_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_GET, S_GROW, S_PLACE, S_FILL, S_SHIFT_UP, S_SHIFT_DN, S_RESP
   } state_type;

   state_type                        state_ff, state_in;
   logic [ils_pkg::CMD_W-1:0]        cmd_ff, cmd_in;
   logic [ils_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [HANDLE_BITS-1:0]           handle_ff, handle_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [CNT_W-1:0]                 cap_ff, cap_in;
   logic [ils_pkg::CFG_W-1:0]        grow_block_ff, grow_block_in;
   logic [ils_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [ils_pkg::HANDLE_W-1:0]     got_ff, got_in;
   logic [ARITH_W-1:0]               tgt_ff, tgt_in;
   logic [ADDR_W-1:0]                idx_ff, idx_in;
   logic [ADDR_W-1:0]                wa_ff, wa_in;
   logic                             pend_ff, pend_in;
   logic                             rd_done_ff, rd_done_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ils_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic [ARITH_W-1:0]               count_w, cap_w, pos_w, tgt_sel, need_w, cfg_w;
   logic [ADDR_W-1:0]                tgt_addr;
   logic [WIDE_W-1:0]                req_wide, rd_wide;

   logic                             ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]                ram_wr_addr, ram_rd_addr;
   logic [HANDLE_BITS-1:0]           ram_wr_data, ram_rd_data;

   logic                             grow_start;
   ils_pkg::grow_status_type         grow_status;
   logic [ARITH_W-1:0]               grow_new_cap;

   // Widened views for the size and index arithmetic.
   assign count_w  = ARITH_W'(count_ff);
   assign cap_w    = ARITH_W'(cap_ff);
   assign pos_w    = ARITH_W'(pos_ff);
   assign cfg_w    = ARITH_W'(csr_wdata);
   assign tgt_addr = tgt_ff[ADDR_W-1:0];
   assign req_wide = WIDE_W'(req_data.handle_in);
   assign rd_wide  = WIDE_W'(ram_rd_data);

   // Target slot (append lands at the end) and the element count the command needs.
   assign tgt_sel = (cmd_ff == ils_pkg::CMD_APPEND) ? count_w : pos_w;
   assign need_w  = (((cmd_ff == ils_pkg::CMD_SET) || (tgt_sel > count_w)) ? tgt_sel : count_w)
                    + ARITH_W'(1);

   // Sequencer next-state logic and memory port control.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      handle_in     = handle_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      grow_block_in = grow_block_ff;
      status_in     = status_ff;
      got_in        = got_ff;
      tgt_in        = tgt_ff;
      idx_in        = idx_ff;
      wa_in         = wa_ff;
      pend_in       = pend_ff;
      rd_done_in    = rd_done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;
      grow_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_data.command;
               pos_in    = req_data.position;
               handle_in = req_wide[HANDLE_BITS-1:0];
               state_in  = S_DECODE;
            end
         end

         S_DECODE: begin
            status_in = ils_pkg::ST_OK;
            got_in    = '0;
            tgt_in    = tgt_sel;
            unique case (cmd_ff) inside
               ils_pkg::CMD_GET: begin
                  if (pos_w < count_w) begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = ADDR_W'(pos_w);
                     state_in    = S_GET;
                  end else begin
                     state_in = S_RESP;
                  end
               end
               ils_pkg::CMD_SET, ils_pkg::CMD_INSERT, ils_pkg::CMD_APPEND: begin
                  if (need_w <= cap_w) begin
                     state_in = S_PLACE;
                  end else if (grow_block_ff == '0) begin
                     status_in = ils_pkg::ST_FULL;
                     state_in  = S_RESP;
                  end else begin
                     grow_start = 1'b1;
                     state_in   = S_GROW;
                  end
               end
               ils_pkg::CMD_REMOVE: begin
                  if (pos_w < count_w) begin
                     idx_in     = ADDR_W'(pos_w + ARITH_W'(1));
                     rd_done_in = (pos_w + ARITH_W'(1)) == count_w;
                     pend_in    = 1'b0;
                     state_in   = S_SHIFT_DN;
                  end else begin
                     status_in = ils_pkg::ST_RANGE;
                     state_in  = S_RESP;
                  end
               end
               ils_pkg::CMD_TRIM: begin
                  if (pos_w < count_w) begin
                     count_in = CNT_W'(pos_w);
                  end else begin
                     status_in = ils_pkg::ST_RANGE;
                  end
                  state_in = S_RESP;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         // Read data of a get arrives in the cycle after the address.
         S_GET: begin
            got_in   = rd_wide[ils_pkg::HANDLE_W-1:0];
            state_in = S_RESP;
         end

         S_GROW: begin
            if (grow_status.done) begin
               if (grow_status.no_room) begin
                  status_in = ils_pkg::ST_NOROOM;
                  state_in  = S_RESP;
               end else begin
                  cap_in   = CNT_W'(grow_new_cap);
                  state_in = S_PLACE;
               end
            end
         end

         // Room is assured: overwrite in place, write at the end, extend over a gap, or open a hole.
         S_PLACE: begin
            if ((cmd_ff == ils_pkg::CMD_SET) && (tgt_ff < count_w)) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = tgt_addr;
               ram_wr_data = handle_ff;
               state_in    = S_RESP;
            end else if (tgt_ff == count_w) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = tgt_addr;
               ram_wr_data = handle_ff;
               count_in    = CNT_W'(tgt_ff + ARITH_W'(1));
               state_in    = S_RESP;
            end else if (tgt_ff > count_w) begin
               idx_in   = ADDR_W'(count_w);
               state_in = S_FILL;
            end else begin
               idx_in     = ADDR_W'(count_w - ARITH_W'(1));
               rd_done_in = 1'b0;
               pend_in    = 1'b0;
               state_in   = S_SHIFT_UP;
            end
         end

         // Zero the gap between the old end and the target, then write the handle.
         S_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            if (idx_ff == tgt_addr) begin
               ram_wr_data = handle_ff;
               count_in    = CNT_W'(tgt_ff + ARITH_W'(1));
               state_in    = S_RESP;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end

         // Move entries up one place, from the top down to the target, streaming
         // a read and the write of the previous read's data in each cycle.
         S_SHIFT_UP: begin
            pend_in = 1'b0;
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = wa_ff;
               ram_wr_data = ram_rd_data;
            end
            if (!rd_done_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff;
               pend_in     = 1'b1;
               wa_in       = idx_ff + ADDR_W'(1);
               if (idx_ff == tgt_addr) begin
                  rd_done_in = 1'b1;
               end else begin
                  idx_in = idx_ff - ADDR_W'(1);
               end
            end else if (!pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = tgt_addr;
               ram_wr_data = handle_ff;
               count_in    = count_ff + CNT_W'(1);
               state_in    = S_RESP;
            end
         end

         // Move entries above the removed one down one place, bottom first.
         S_SHIFT_DN: begin
            pend_in = 1'b0;
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = wa_ff;
               ram_wr_data = ram_rd_data;
            end
            if (!rd_done_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff;
               pend_in     = 1'b1;
               wa_in       = idx_ff - ADDR_W'(1);
               if ((ARITH_W'(idx_ff) + ARITH_W'(1)) == count_w) begin
                  rd_done_in = 1'b1;
               end else begin
                  idx_in = idx_ff + ADDR_W'(1);
               end
            end else if (!pend_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_RESP;
            end
         end

         // Hand the result to the output register once it is free.
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.status     = status_ff;
               rsp_data_in.handle_out = got_ff;
               rsp_data_in.length     = count_w[ils_pkg::LEN_W-1:0];
               rsp_data_in.room       = cap_w[ils_pkg::LEN_W-1:0];
               state_in               = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The user must make configuration writes only while the block is idle; the block does not enforce it.
      if (csr_write) begin
         unique case (csr_index)
            ils_pkg::REG_START_CAP: begin
               count_in = '0;
               cap_in   = (cfg_w > DEPTH_W) ? CNT_W'(STORE_DEPTH) : CNT_W'(cfg_w);
            end
            ils_pkg::REG_GROW_BLOCK: begin
               grow_block_in = csr_wdata;
            end
            default: begin
               grow_block_in = grow_block_ff;
            end
         endcase
      end
   end

   // State, control registers and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         cap_ff        <= CNT_W'(ils_pkg::START_CAP_RESET);
         grow_block_ff <= ils_pkg::GROW_BLOCK_RESET;
         pend_ff       <= 1'b0;
         rd_done_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cap_ff        <= cap_in;
         grow_block_ff <= grow_block_in;
         pend_ff       <= pend_in;
         rd_done_ff    <= rd_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      pos_ff      <= pos_in;
      handle_ff   <= handle_in;
      status_ff   <= status_in;
      got_ff      <= got_in;
      tgt_ff      <= tgt_in;
      idx_ff      <= idx_in;
      wa_ff       <= wa_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Slot memory.
   ils_ram #(
      .WIDTH (HANDLE_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Block-count arithmetic for capacity growth.
   ils_grow #(
      .ARITH_W     (ARITH_W),
      .STORE_DEPTH (STORE_DEPTH)
   ) u_grow (
      .clock  (clock),
      .reset  (reset),
      .start  (grow_start),
      .need   (need_w),
      .cap    (cap_w),
      .block  (grow_block_ff),
      .status (grow_status),
      .grown  (grow_new_cap)
   );

   // A shift never reads the slot it writes in the same cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en && (ram_wr_addr == ram_rd_addr)))
      else $error("slot memory read and written at the same address");

   // The list never outgrows its capacity.
   a_count_in_cap: assert property (@(posedge clock) disable iff (reset)
      count_w <= cap_w)
      else $error("list length exceeds capacity");

   // Capacity only shrinks through a start capacity write.
   a_cap_monotonic: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(csr_write)) |-> (cap_w >= $past(cap_w)))
      else $error("capacity fell without reinitialisation");

endmodule

@@ test/ils_checker.sv @@
// Response checker for the indexed list store: mirrors the list and compares every beat.
`timescale 1ns / 100ps

module ils_checker
   import ils_pkg::*;
#(
   parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   // Mirror of the list contents, its length, capacity and the two registers.
   logic [HANDLE_W-1:0] shadow_slots [STORE_DEPTH];
   int shadow_len;
   int shadow_cap;
   int cfg_start;
   int cfg_grow;

   // Responses predicted for accepted request beats, oldest first.
   rsp_type awaited_rsp [$];

   // Empties the list and loads the starting capacity, saturated at the depth.
   function automatic void clear_shadow();
      foreach (shadow_slots[i]) shadow_slots[i] = '0;
      shadow_len = 0;
      shadow_cap = (cfg_start > STORE_DEPTH) ? STORE_DEPTH : cfg_start;
   endfunction

   // Makes room for extra more elements, growing in whole blocks with one spare block.
   function automatic logic [STATUS_W-1:0] reserve(int extra);
      int need;
      int blocks;
      int grown;
      need = shadow_len + extra;
      if (need <= shadow_cap) return ST_OK;
      if (cfg_grow == 0) return ST_FULL;
      blocks = (need - shadow_cap + cfg_grow) / cfg_grow;
      grown = shadow_cap + blocks * cfg_grow;
      if (grown > STORE_DEPTH) return ST_NOROOM;
      shadow_cap = grown;
      return ST_OK;
   endfunction

   // Inserts a handle at pos, shifting later entries up; past the end leaves a zero gap.
   function automatic logic [STATUS_W-1:0] place(int pos, logic [HANDLE_W-1:0] handle);
      logic [STATUS_W-1:0] st;
      st = reserve(pos > shadow_len ? pos + 1 - shadow_len : 1);
      if (st != ST_OK) return st;
      if (pos >= STORE_DEPTH || shadow_len >= STORE_DEPTH) return ST_NOROOM;
      for (int i = shadow_len; i > pos; i--) shadow_slots[i] = shadow_slots[i - 1];
      shadow_slots[pos] = handle;
      shadow_len = (pos > shadow_len) ? pos + 1 : shadow_len + 1;
      return ST_OK;
   endfunction

   // Applies one command to the mirror and returns the response it should produce.
   function automatic rsp_type next_response(req_type cmd_beat);
      rsp_type res;
      int pos;
      res = '0;
      pos = int'(cmd_beat.position);
      res.status = ST_OK;
      case (cmd_beat.command)
         CMD_GET: begin
            if (pos < shadow_len) res.handle_out = shadow_slots[pos];
         end
         CMD_SET: begin
            if (pos >= shadow_cap) res.status = reserve(pos + 1 - shadow_len);
            if (res.status == ST_OK) begin
               if (pos >= STORE_DEPTH) begin
                  res.status = ST_NOROOM;
               end else begin
                  shadow_slots[pos] = cmd_beat.handle_in;
                  if (pos >= shadow_len) shadow_len = pos + 1;
               end
            end
         end
         CMD_INSERT: begin
            res.status = place(pos, cmd_beat.handle_in);
         end
         CMD_REMOVE: begin
            if (pos >= shadow_len) begin
               res.status = ST_RANGE;
            end else begin
               for (int i = pos + 1; i < shadow_len; i++) shadow_slots[i - 1] = shadow_slots[i];
               shadow_len--;
               shadow_slots[shadow_len] = '0;
            end
         end
         CMD_TRIM: begin
            if (pos >= shadow_len) begin
               res.status = ST_RANGE;
            end else begin
               for (int i = pos; i < shadow_len; i++) shadow_slots[i] = '0;
               shadow_len = pos;
            end
         end
         CMD_APPEND: begin
            res.status = place(shadow_len, cmd_beat.handle_in);
         end
         default: begin
            // The spare codes leave everything as it is.
         end
      endcase
      res.length = shadow_len[LEN_W-1:0];
      res.room = shadow_cap[LEN_W-1:0];
      return res;
   endfunction

   // Reports one field that differs from its prediction.
   task automatic check_field(input string field, input logic [HANDLE_W-1:0] want,
                              input logic [HANDLE_W-1:0] got);
      if (want !== got) begin
         if (fail_count < 40)
            $display("%0t ils_checker: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
         fail_count++;
      end
   endtask

   // Responses are matched before new requests are predicted, as a beat never
   // leaves in the cycle its request arrives.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_start = int'(START_CAP_RESET);
         cfg_grow = int'(GROW_BLOCK_RESET);
         clear_shadow();
         awaited_rsp.delete();
         pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               if (fail_count < 40)
                  $display("%0t ils_checker: response beat with none expected, actual %p",
                           $time, rsp_data);
               fail_count++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("status", HANDLE_W'(want.status), HANDLE_W'(rsp_data.status));
               check_field("handle_out", want.handle_out, rsp_data.handle_out);
               check_field("length", HANDLE_W'(want.length), HANDLE_W'(rsp_data.length));
               check_field("room", HANDLE_W'(want.room), HANDLE_W'(rsp_data.room));
            end
         end
         if (req_valid && req_ready) awaited_rsp.push_back(next_response(req_data));
         if (csr_write) begin
            if (csr_index == REG_START_CAP) begin
               cfg_start = int'(csr_wdata);
               clear_shadow();
            end else begin
               cfg_grow = int'(csr_wdata);
            end
         end
         pending <= awaited_rsp.size();
      end
   end

endmodule

@@ test/tb_indexed_list_store.sv @@
// Testbench top for the indexed list store: stimulus, idling, watchdog and verdict.
`timescale 1ns / 100ps

module tb_indexed_list_store;
   import ils_pkg::*;

   localparam int ITEMS_PER_PHASE = 225;
   localparam int PHASES = 6;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 300;

   // Command codes the block does not use.
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;

   int fail_count;
   int pending;
   int tx_idle_pct;
   int rx_idle_pct;
   int hold_asked;
   int hold_served;
   int hold_left;
   int quiet_cycles;

   indexed_list_store u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ils_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Response side: random stalls, or a long hold-off when the stimulus asks for one.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_served) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES - 1;
         hold_served <= hold_served + 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // Watchdog: too long without any beat on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_indexed_list_store: FAIL");
         $finish;
      end
   end

   // Offers one request beat after a random gap and waits until it is taken.
   task automatic send(input req_type item);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic issue(input logic [CMD_W-1:0] cmd, input int pos,
                        input logic [HANDLE_W-1:0] handle);
      req_type item;
      item.command = cmd;
      item.position = pos[POS_W-1:0];
      item.handle_in = handle;
      send(item);
   endtask

   // Stops offering and waits until every predicted response beat has arrived.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Writes both registers once the block is idle; the start capacity clears the list.
   task automatic configure(input int start_cap, input int grow);
      settle();
      csr_write <= 1'b1;
      csr_index <= REG_GROW_BLOCK;
      csr_wdata <= grow[CFG_W-1:0];
      @(posedge clock);
      csr_index <= REG_START_CAP;
      csr_wdata <= start_cap[CFG_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Mostly list-building commands near the front, with some far positions and spare codes.
   function automatic req_type random_request();
      req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) r.command = CMD_APPEND;
      else if (pick < 45) r.command = CMD_INSERT;
      else if (pick < 63) r.command = CMD_GET;
      else if (pick < 75) r.command = CMD_SET;
      else if (pick < 88) r.command = CMD_REMOVE;
      else if (pick < 95) r.command = CMD_TRIM;
      else r.command = pick[0] ? CMD_SPARE_LO : CMD_SPARE_HI;
      pick = $urandom_range(0, 9);
      if (pick < 6) r.position = POS_W'($urandom_range(0, 31));
      else if (pick < 9) r.position = POS_W'($urandom_range(0, 127));
      else r.position = POS_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 19);
      if (pick == 0) r.handle_in = '0;
      else if (pick == 1) r.handle_in = '1;
      else r.handle_in = $urandom;
      return r;
   endfunction

   initial begin
      req_type item;
      int done_items;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      tx_idle_pct = 24;
      rx_idle_pct = 83;
      hold_asked = 0;
      hold_served = 0;
      hold_left = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings: empty list, extremes and open cases.
      issue(CMD_GET, 0, 32'h0);
      issue(CMD_APPEND, 0, 32'hFFFF_FFFF);
      issue(CMD_APPEND, 255, 32'h0000_0000);
      issue(CMD_APPEND, 0, 32'hA5A5_A5A5);
      issue(CMD_INSERT, 0, 32'h1111_1111);
      issue(CMD_INSERT, 2, 32'h2222_2222);
      issue(CMD_GET, 255, 32'hFFFF_FFFF);
      issue(CMD_GET, 1, 32'h0);
      // Set inside the capacity but past the end leaves a zero gap.
      issue(CMD_SET, 6, 32'h5A5A_5A5A);
      issue(CMD_GET, 5, 32'h0);
      // Set and insert past the capacity grow first.
      issue(CMD_SET, 20, 32'h8000_0001);
      issue(CMD_INSERT, 40, 32'h7FFF_FFFE);
      issue(CMD_REMOVE, 0, 32'h0);
      issue(CMD_REMOVE, 200, 32'h0);
      issue(CMD_TRIM, 100, 32'h0);
      issue(CMD_SPARE_LO, 0, 32'h0);
      issue(CMD_SPARE_HI, 255, 32'hFFFF_FFFF);
      issue(CMD_TRIM, 3, 32'h0);
      issue(CMD_GET, 2, 32'h0);
      // Growth that would pass the store depth.
      issue(CMD_SET, 255, 32'hDEAD_BEEF);
      issue(CMD_INSERT, 255, 32'hCAFE_F00D);

      // Growth disabled: a small list fills up and then reports full.
      configure(4, 0);
      repeat (5) issue(CMD_APPEND, 0, $urandom);

      // Random phases, each with its own register settings and idling pattern.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 2) begin
            tx_idle_pct = 83;
            rx_idle_pct = 24;
         end else if (phase == 4) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         case (phase)
            0: configure(0, 1);
            1: configure(16, 0);
            2: configure(256, 256);
            3: configure(511, 511);
            4: configure(3, $urandom_range(2, 40));
            default: configure($urandom_range(0, 300), $urandom_range(1, 256));
         endcase
         // Hold the response side off so the block fills and stalls its input.
         if (phase == 4) hold_asked = hold_asked + 1;
         done_items = 0;
         while (done_items < ITEMS_PER_PHASE) begin
            item = random_request();
            send(item);
            if (item.command <= CMD_APPEND) done_items++;
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_indexed_list_store: PASS");
      end else begin
         $display("tb_indexed_list_store: FAIL");
      end
      $finish;
   end

endmodule
